FILE: hw/rtl/hvts_pkg.sv
// Package with the shared types and constants of the thermostat sequencer.
`timescale 1ns / 1ps

package hvts_pkg;

    // Item commands.
    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_SAMPLE  = 2'd0;
    localparam cmd_t CMD_PROCESS = 2'd1;
    localparam cmd_t CMD_TICK    = 2'd2;
    localparam cmd_t CMD_CLEAR   = 2'd3;

    // Configuration register indexes.
    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_SETPOINT   = 3'd0;
    localparam reg_idx_t REG_HYSTERESIS = 3'd1;
    localparam reg_idx_t REG_OFFSET     = 3'd2;
    localparam reg_idx_t REG_MODE       = 3'd3;
    localparam reg_idx_t REG_LIMIT_LOW  = 3'd4;
    localparam reg_idx_t REG_LIMIT_HIGH = 3'd5;
    localparam reg_idx_t REG_MIN_ON     = 3'd6;
    localparam reg_idx_t REG_MIN_OFF    = 3'd7;

    // Operating modes; seven behaves as disabled.
    typedef logic [2:0] mode_t;
    localparam mode_t MODE_OFF      = 3'd0;
    localparam mode_t MODE_COOL     = 3'd1;
    localparam mode_t MODE_HEAT     = 3'd2;
    localparam mode_t MODE_AUTO     = 3'd3;
    localparam mode_t MODE_FAN      = 3'd4;
    localparam mode_t MODE_MANUAL   = 3'd5;
    localparam mode_t MODE_DISABLED = 3'd6;

    // Configuration data width and register field widths.
    localparam int CFG_DATA_BITS = 24;
    localparam int SETPOINT_BITS = 10;
    localparam int HYST_BITS     = 7;
    localparam int OFFSET_BITS   = 9;
    localparam int LIMIT_BITS    = 12;
    localparam int TICKS_BITS    = 24;
    localparam int COUNT_BITS    = 32;

    // Temperature constants in 1/16 degree C.
    localparam int VALID_LOW      = -800;
    localparam int VALID_HIGH     = 1600;
    localparam int AUTO_BAND      = 32;
    localparam int TEMP_RESET     = 320;
    localparam int MIN_SEEN_RESET = 1600;
    localparam int MAX_SEEN_RESET = -1600;

    // Register reset values.
    localparam int SETPOINT_RESET   = 384;
    localparam int HYST_RESET       = 16;
    localparam int LIMIT_LOW_RESET  = -160;
    localparam int LIMIT_HIGH_RESET = 800;
    localparam int TICKS_RESET      = 180000;

endpackage

FILE: hw/rtl/hvac_thermostat_sequencer_unit.sv
// Hysteresis thermostat with compressor and heater short-cycle protection.
//
// Usage: items arrive on the s_ channel (command, temperature) with valid and
// ready. Each accepted beat yields exactly one result beat on the m_ channel
// that shows the load drives, latch, reading and statistics after the item.
// Configuration registers are written through the cfg_ channel while the
// block is idle; a write to the mode register restarts both load timers.
// Latency: the result of an item is presented in the cycle after the item is
// accepted. Throughput: one item per cycle unless a stall holds it off; the
// state update is a single pass of compares and adds between the accepted
// beat and the state registers, which also serve as the result register.
// Stalls: while a result waits for m_ready the input is held off, so the
// result stays stable; a beat is taken in the same cycle the result leaves.
// A configuration write that is offered holds off new items for that cycle.
// Reset: aresetn is synchronous and active low; registers return to their
// reset values (mode disabled, loads off, 20 C reading) and no result is
// pending. There is no clearing pass, so items are taken right after reset.
`timescale 1ns / 1ps

module hvac_thermostat_sequencer_unit #(
    parameter int TIMER_BITS = 24,
    parameter int TEMP_BITS  = 13
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Item channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  hvts_pkg::cmd_t                         s_command,
    input  logic signed [TEMP_BITS-1:0]            s_temperature,
    // Result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_compressor_on,
    output logic                                   m_heater_on,
    output logic                                   m_fan_on,
    output logic                                   m_emergency,
    output logic                                   m_reading_valid,
    output logic signed [TEMP_BITS-1:0]            m_compensated,
    output logic signed [TEMP_BITS-1:0]            m_lowest_seen,
    output logic signed [TEMP_BITS-1:0]            m_highest_seen,
    output logic [hvts_pkg::COUNT_BITS-1:0]        m_start_count,
    // Configuration channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  hvts_pkg::reg_idx_t                     cfg_index,
    input  logic [hvts_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import hvts_pkg::*;

    // Width for signed compares: room for sensor, offset, setpoint and band.
    localparam int CW = TEMP_BITS + 3;
    localparam int MW = (TIMER_BITS > TICKS_BITS) ? TIMER_BITS : TICKS_BITS;
    localparam logic signed [CW-1:0] T_MAX  = CW'((1 <<< (TEMP_BITS - 1)) - 1);
    localparam logic signed [CW-1:0] T_MIN  = -T_MAX - CW'(1);
    localparam logic signed [CW-1:0] V_LOW  = CW'(VALID_LOW);
    localparam logic signed [CW-1:0] V_HIGH = CW'(VALID_HIGH);
    localparam logic signed [CW-1:0] BAND   = CW'(AUTO_BAND);

    // Configuration registers.
    logic [SETPOINT_BITS-1:0]     setpoint_reg;
    logic [HYST_BITS-1:0]         hyst_reg;
    logic signed [OFFSET_BITS-1:0] offset_reg;
    mode_t                        mode_reg;
    logic signed [LIMIT_BITS-1:0] limit_low_reg;
    logic signed [LIMIT_BITS-1:0] limit_high_reg;
    logic [TICKS_BITS-1:0]        min_on_reg;
    logic [TICKS_BITS-1:0]        min_off_reg;

    // Block state; these registers also drive the result fields.
    logic                         comp_reg, comp_next;
    logic                         heat_reg, heat_next;
    logic                         fan_reg, fan_next;
    logic                         estop_reg, estop_next;
    logic                         rvalid_reg, rvalid_next;
    logic signed [TEMP_BITS-1:0]  temp_reg, temp_next;
    logic signed [TEMP_BITS-1:0]  min_reg, min_next;
    logic signed [TEMP_BITS-1:0]  max_reg, max_next;
    logic [TIMER_BITS-1:0]        comp_el_reg, comp_el_next;
    logic [TIMER_BITS-1:0]        heat_el_reg, heat_el_next;
    logic [COUNT_BITS-1:0]        starts_reg, starts_next;
    logic                         out_valid_reg;

    logic                         item_acc;
    logic                         cfg_acc;

    // Extended operands for the sample and process paths.
    logic signed [CW-1:0]         t_w, off_w, sum_w, c_w, ct_w;
    logic signed [CW-1:0]         sp_w, hys_w, lo_w, hi_w;
    logic signed [TEMP_BITS-1:0]  c_sat;
    logic                         sample_ok;
    logic                         want_cool, want_heat;
    logic                         wc, wh, wf;
    logic                         comp_may, heat_may;
    logic [MW-1:0]                comp_el_w, heat_el_w, min_on_w, min_off_w;

    // Handshakes: items wait while a result is stuck or a write is offered.
    assign s_ready   = (!out_valid_reg || m_ready) && !cfg_valid;
    assign cfg_ready = !out_valid_reg;
    assign item_acc  = s_valid && s_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;

    // Sign and zero extension of the operands.
    assign t_w   = CW'(s_temperature);
    assign off_w = CW'(offset_reg);
    assign ct_w  = CW'(temp_reg);
    assign sp_w  = signed'({{(CW - SETPOINT_BITS){1'b0}}, setpoint_reg});
    assign hys_w = signed'({{(CW - HYST_BITS){1'b0}}, hyst_reg});
    assign lo_w  = CW'(limit_low_reg);
    assign hi_w  = CW'(limit_high_reg);

    // Sample path: range check, offset add and saturation.
    assign sample_ok = (t_w > V_LOW) && (t_w < V_HIGH);
    assign sum_w     = t_w + off_w;
    always_comb begin
        if (sum_w > T_MAX) begin
            c_w = T_MAX;
        end else if (sum_w < T_MIN) begin
            c_w = T_MIN;
        end else begin
            c_w = sum_w;
        end
    end
    assign c_sat = c_w[TEMP_BITS-1:0];

    // Hysteresis demands against the held reading.
    assign want_cool = comp_reg ? (ct_w > sp_w - hys_w) : (ct_w > sp_w);
    assign want_heat = heat_reg ? (ct_w < sp_w + hys_w) : (ct_w < sp_w);

    // Wanted loads for the current mode.
    always_comb begin
        wc = 1'b0;
        wh = 1'b0;
        wf = 1'b0;
        case (mode_reg)
            MODE_COOL: begin
                wc = want_cool;
                wf = want_cool;
            end
            MODE_HEAT: begin
                wh = want_heat;
                wf = want_heat;
            end
            MODE_AUTO: begin
                if (ct_w > sp_w + BAND) begin
                    wc = want_cool;
                    wf = want_cool;
                end else if (ct_w < sp_w - BAND) begin
                    wh = want_heat;
                    wf = want_heat;
                end
            end
            MODE_FAN: begin
                wf = 1'b1;
            end
            MODE_MANUAL: begin
                wc = comp_reg;
                wh = heat_reg;
                wf = fan_reg;
            end
            default: begin
                wc = 1'b0;
            end
        endcase
    end

    // Short-cycle guard: a demand changes a load only after its minimum time.
    assign comp_el_w = MW'(comp_el_reg);
    assign heat_el_w = MW'(heat_el_reg);
    assign min_on_w  = MW'(min_on_reg);
    assign min_off_w = MW'(min_off_reg);
    assign comp_may  = comp_reg ? (comp_el_w >= min_on_w) : (comp_el_w >= min_off_w);
    assign heat_may  = heat_reg ? (heat_el_w >= min_on_w) : (heat_el_w >= min_off_w);

    // Next state for one accepted item.
    always_comb begin
        comp_next    = comp_reg;
        heat_next    = heat_reg;
        fan_next     = fan_reg;
        estop_next   = estop_reg;
        rvalid_next  = rvalid_reg;
        temp_next    = temp_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        comp_el_next = comp_el_reg;
        heat_el_next = heat_el_reg;
        starts_next  = starts_reg;
        case (s_command)
            CMD_SAMPLE: begin
                rvalid_next = sample_ok;
                if (sample_ok) begin
                    temp_next = c_sat;
                    if (c_sat < min_reg) begin
                        min_next = c_sat;
                    end
                    if (c_sat > max_reg) begin
                        max_next = c_sat;
                    end
                    if (c_w >= hi_w || c_w <= lo_w) begin
                        estop_next = 1'b1;
                        comp_next  = 1'b0;
                        heat_next  = 1'b0;
                        fan_next   = 1'b0;
                    end
                end
            end
            CMD_PROCESS: begin
                if (estop_reg) begin
                    comp_next = 1'b0;
                    heat_next = 1'b0;
                    fan_next  = 1'b0;
                end else if (mode_reg < MODE_DISABLED && rvalid_reg) begin
                    if (wc != comp_reg && comp_may) begin
                        comp_next    = wc;
                        comp_el_next = '0;
                        if (wc && starts_reg != '1) begin
                            starts_next = starts_reg + COUNT_BITS'(1);
                        end
                    end
                    if (wh != heat_reg && heat_may) begin
                        heat_next    = wh;
                        heat_el_next = '0;
                    end
                    fan_next = wf;
                end
            end
            CMD_TICK: begin
                if (comp_el_reg != '1) begin
                    comp_el_next = comp_el_reg + TIMER_BITS'(1);
                end
                if (heat_el_reg != '1) begin
                    heat_el_next = heat_el_reg + TIMER_BITS'(1);
                end
            end
            default: begin
                estop_next = 1'b0;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg   <= SETPOINT_BITS'(SETPOINT_RESET);
            hyst_reg       <= HYST_BITS'(HYST_RESET);
            offset_reg     <= '0;
            mode_reg       <= MODE_DISABLED;
            limit_low_reg  <= LIMIT_BITS'(LIMIT_LOW_RESET);
            limit_high_reg <= LIMIT_BITS'(LIMIT_HIGH_RESET);
            min_on_reg     <= TICKS_BITS'(TICKS_RESET);
            min_off_reg    <= TICKS_BITS'(TICKS_RESET);
        end else if (cfg_acc) begin
            case (cfg_index)
                REG_SETPOINT:   setpoint_reg   <= cfg_data[SETPOINT_BITS-1:0];
                REG_HYSTERESIS: hyst_reg       <= cfg_data[HYST_BITS-1:0];
                REG_OFFSET:     offset_reg     <= cfg_data[OFFSET_BITS-1:0];
                REG_MODE:       mode_reg       <= cfg_data[2:0];
                REG_LIMIT_LOW:  limit_low_reg  <= cfg_data[LIMIT_BITS-1:0];
                REG_LIMIT_HIGH: limit_high_reg <= cfg_data[LIMIT_BITS-1:0];
                REG_MIN_ON:     min_on_reg     <= cfg_data[TICKS_BITS-1:0];
                REG_MIN_OFF:    min_off_reg    <= cfg_data[TICKS_BITS-1:0];
                default:        setpoint_reg   <= setpoint_reg;
            endcase
        end
    end

    // Block state: a mode write restarts timers, otherwise items update it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            comp_reg    <= 1'b0;
            heat_reg    <= 1'b0;
            fan_reg     <= 1'b0;
            estop_reg   <= 1'b0;
            rvalid_reg  <= 1'b0;
            temp_reg    <= TEMP_BITS'(TEMP_RESET);
            min_reg     <= TEMP_BITS'(MIN_SEEN_RESET);
            max_reg     <= TEMP_BITS'(MAX_SEEN_RESET);
            comp_el_reg <= '0;
            heat_el_reg <= '0;
            starts_reg  <= '0;
        end else if (cfg_acc) begin
            if (cfg_index == REG_MODE) begin
                comp_el_reg <= '0;
                heat_el_reg <= '0;
                if (cfg_data[2:0] >= MODE_DISABLED) begin
                    comp_reg <= 1'b0;
                    heat_reg <= 1'b0;
                    fan_reg  <= 1'b0;
                end
            end
        end else if (item_acc) begin
            comp_reg    <= comp_next;
            heat_reg    <= heat_next;
            fan_reg     <= fan_next;
            estop_reg   <= estop_next;
            rvalid_reg  <= rvalid_next;
            temp_reg    <= temp_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            comp_el_reg <= comp_el_next;
            heat_el_reg <= heat_el_next;
            starts_reg  <= starts_next;
        end
    end

    // Result beat flag: set by each item, cleared when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (item_acc) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result fields come straight from the state registers.
    assign m_valid         = out_valid_reg;
    assign m_compressor_on = comp_reg;
    assign m_heater_on     = heat_reg;
    assign m_fan_on        = fan_reg;
    assign m_emergency     = estop_reg;
    assign m_reading_valid = rvalid_reg;
    assign m_compensated   = temp_reg;
    assign m_lowest_seen   = min_reg;
    assign m_highest_seen  = max_reg;
    assign m_start_count   = starts_reg;

    // While the emergency latch is set, every load is off.
    assert property (@(posedge aclk) disable iff (!aresetn)
        estop_reg |-> (!comp_reg && !heat_reg && !fan_reg))
        else $error("load on while emergency latch is set");

    // A compressor start bumps the start count unless it has saturated.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(comp_reg) |-> (starts_reg == $past(starts_reg) + COUNT_BITS'(1)
                             || $past(starts_reg) == '1))
        else $error("compressor start not counted");

    // A stalled result keeps the state it reports.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> ($stable(temp_reg) && $stable(starts_reg)
                                         && $stable(comp_reg)))
        else $error("state changed under a stalled result");

endmodule
